>>> rtl/bgmc_pkg.sv
// Package for the button gesture mode controller: time width, register
// indexes and reset values, event and mode codes, LED color lookup.
// No dependencies.
package bgmc_pkg;

	localparam int TIME_BITS = 48;

	typedef logic [TIME_BITS-1:0] time_t;

	localparam int LONG_W  = 24;
	localparam int MIN_W   = 20;
	localparam int GAP_W   = 24;
	localparam int CFG_W   = 24;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LONG_PRESS = 2'd0,
		REG_MIN_PRESS  = 2'd1,
		REG_DOUBLE_GAP = 2'd2
	} reg_idx_t;

	localparam logic [LONG_W-1:0] LONG_PRESS_RST = 24'd3000000;
	localparam logic [MIN_W-1:0]  MIN_PRESS_RST  = 20'd50000;
	localparam logic [GAP_W-1:0]  DOUBLE_GAP_RST = 24'd500000;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_MODE     = 3'd1,
		EV_GENERATE = 3'd2,
		EV_NEXT     = 3'd3,
		EV_ACK      = 3'd4
	} event_t;

	typedef enum logic [1:0] {
		MODE_SMARTCARD = 2'd0,
		MODE_KEYBOARD  = 2'd1,
		MODE_SETUP     = 2'd2
	} mode_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	localparam logic [7:0] LED_FULL = 8'd255;
	localparam logic [7:0] LED_HALF = 8'd128;
	localparam logic [7:0] LED_OFF  = 8'd0;

	function automatic rgb_t mode_color(input mode_t m, input logic synced);
		rgb_t c;
		unique case (m)
			MODE_SMARTCARD: c = '{synced ? LED_OFF : LED_FULL, LED_FULL, LED_OFF};
			MODE_KEYBOARD:  c = '{synced ? LED_OFF : LED_FULL, LED_OFF, LED_FULL};
			default:        c = '{LED_FULL, LED_HALF, LED_OFF};
		endcase
		return c;
	endfunction

endpackage

>>> rtl/button_gesture_mode_controller_unit.sv
// Button gesture mode controller: press tracking, long-press mode cycling,
// short-press events and LED color per sample. Depends on bgmc_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one sample word: now_us,
//   button_down, time_synced. Output channel (out_valid / out_stall) gives
//   one result word per sample: event_code, mode, led_red/green/blue.
//   A word moves when valid is high and stall is low.
//   Path: an accepted sample sits in the input register, is evaluated
//   against the gesture state and is registered in the result register.
//   Throughput: one sample per cycle unless out_stall holds the result,
//   set by the single evaluation stage between input and result registers.
//   Receiver stall: the result register holds; the input register keeps its
//   sample and in_stall rises once both registers are full.
//   Configuration: cfg_we writes cfg_data into the register at cfg_index
//   (0 long press, 1 minimum press, 2 double-press gap); write while idle.
//   Reset: arst_n clears mode to ccid, press tracking, the release history,
//   both valid flags, and loads the default timing registers.
module button_gesture_mode_controller_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bgmc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bgmc_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [bgmc_pkg::TIME_BITS-1:0]   now_us,
	input  logic                             button_down,
	input  logic                             time_synced,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [2:0]                       event_code,
	output logic [1:0]                       mode,
	output logic [7:0]                       led_red,
	output logic [7:0]                       led_green,
	output logic [7:0]                       led_blue
);

	logic [bgmc_pkg::LONG_W-1:0] long_press_q;
	logic [bgmc_pkg::MIN_W-1:0]  min_press_q;
	logic [bgmc_pkg::GAP_W-1:0]  double_gap_q;

	bgmc_pkg::mode_t  mode_q;
	logic             held_q;
	logic             long_seen_q;
	bgmc_pkg::time_t  press_start_q;
	bgmc_pkg::time_t  last_release_q;
	logic             release_seen_q;

	logic             valid_s1;
	bgmc_pkg::time_t  now_s1;
	logic             down_s1;
	logic             synced_s1;

	logic             out_valid_q;
	bgmc_pkg::event_t event_q;
	bgmc_pkg::mode_t  mode_out_q;
	bgmc_pkg::rgb_t   rgb_q;

	logic             advance;
	bgmc_pkg::time_t  dur;
	bgmc_pkg::time_t  gap;
	bgmc_pkg::event_t ev_d;
	bgmc_pkg::mode_t  mode_d;
	bgmc_pkg::mode_t  mode_next;
	logic             held_d;
	logic             long_seen_d;
	logic             press_upd;
	logic             release_upd;

	assign advance  = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q <= bgmc_pkg::LONG_PRESS_RST;
			min_press_q  <= bgmc_pkg::MIN_PRESS_RST;
			double_gap_q <= bgmc_pkg::DOUBLE_GAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bgmc_pkg::REG_LONG_PRESS: long_press_q <= cfg_data[bgmc_pkg::LONG_W-1:0];
				bgmc_pkg::REG_MIN_PRESS:  min_press_q  <= cfg_data[bgmc_pkg::MIN_W-1:0];
				bgmc_pkg::REG_DOUBLE_GAP: double_gap_q <= cfg_data[bgmc_pkg::GAP_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			now_s1    <= now_us;
			down_s1   <= button_down;
			synced_s1 <= time_synced;
		end
	end

	assign dur = now_s1 - press_start_q;
	assign gap = now_s1 - last_release_q;

	always_comb begin
		unique case (mode_q)
			bgmc_pkg::MODE_SMARTCARD: mode_next = bgmc_pkg::MODE_KEYBOARD;
			bgmc_pkg::MODE_KEYBOARD:  mode_next = bgmc_pkg::MODE_SETUP;
			default:                  mode_next = bgmc_pkg::MODE_SMARTCARD;
		endcase
	end

	always_comb begin
		ev_d        = bgmc_pkg::EV_NONE;
		mode_d      = mode_q;
		held_d      = held_q;
		long_seen_d = long_seen_q;
		press_upd   = 1'b0;
		release_upd = 1'b0;
		if (down_s1 && !held_q) begin
			held_d    = 1'b1;
			press_upd = 1'b1;
		end else if (!down_s1 && held_q) begin
			if (!long_seen_q && dur > bgmc_pkg::time_t'(min_press_q)) begin
				if (mode_q == bgmc_pkg::MODE_KEYBOARD) begin
					ev_d = (release_seen_q && gap < bgmc_pkg::time_t'(double_gap_q)) ?
						bgmc_pkg::EV_NEXT : bgmc_pkg::EV_GENERATE;
				end else if (mode_q == bgmc_pkg::MODE_SMARTCARD) begin
					ev_d = bgmc_pkg::EV_ACK;
				end
			end
			release_upd = 1'b1;
			held_d      = 1'b0;
			long_seen_d = 1'b0;
		end else if (down_s1 && held_q) begin
			if (dur > bgmc_pkg::time_t'(long_press_q) && !long_seen_q) begin
				long_seen_d = 1'b1;
				mode_d      = mode_next;
				ev_d        = bgmc_pkg::EV_MODE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= bgmc_pkg::MODE_SMARTCARD;
			held_q         <= 1'b0;
			long_seen_q    <= 1'b0;
			press_start_q  <= '0;
			last_release_q <= '0;
			release_seen_q <= 1'b0;
		end else if (advance) begin
			mode_q      <= mode_d;
			held_q      <= held_d;
			long_seen_q <= long_seen_d;
			if (press_upd) begin
				press_start_q <= now_s1;
			end
			if (release_upd) begin
				last_release_q <= now_s1;
				release_seen_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!(out_valid_q && out_stall)) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q    <= ev_d;
			mode_out_q <= mode_d;
			rgb_q      <= bgmc_pkg::mode_color(mode_d, synced_s1);
		end
	end

	assign out_valid  = out_valid_q;
	assign event_code = event_q;
	assign mode       = mode_out_q;
	assign led_red    = rgb_q.red;
	assign led_green  = rgb_q.green;
	assign led_blue   = rgb_q.blue;

endmodule

>>> rtl/bgmc_checker.sv
// Port-level checks for the button gesture mode controller, bound to the
// top level. Depends on bgmc_pkg and button_gesture_mode_controller_unit.
module bgmc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] event_code,
	input logic [1:0] mode,
	input logic [7:0] led_red,
	input logic [7:0] led_green,
	input logic [7:0] led_blue
);

	// stalled result word holds its event code and mode
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_code) && $stable(mode))
		else $error("result word changed under stall");

	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> mode != 2'd3)
		else $error("unused mode code on output");

	a_cfg_color: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode == bgmc_pkg::MODE_SETUP |->
			led_red == bgmc_pkg::LED_FULL && led_green == bgmc_pkg::LED_HALF &&
			led_blue == bgmc_pkg::LED_OFF)
		else $error("config mode color wrong");

	a_event_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_code == bgmc_pkg::EV_GENERATE ||
			event_code == bgmc_pkg::EV_NEXT) |-> mode == bgmc_pkg::MODE_KEYBOARD)
		else $error("hid event outside hid mode");

	a_ack_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_code == bgmc_pkg::EV_ACK |-> mode == bgmc_pkg::MODE_SMARTCARD)
		else $error("acknowledge outside ccid mode");

endmodule

bind button_gesture_mode_controller_unit bgmc_checker u_bgmc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.event_code (event_code),
	.mode       (mode),
	.led_red    (led_red),
	.led_green  (led_green),
	.led_blue   (led_blue)
);
